### hw/rtl/olist_pkg.sv
`default_nettype none

package olist_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);

    // fixed field widths of the words on the ports
    localparam int MODE_W  = 2;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef logic [VALUE_BITS-1:0] entry_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  status;
    } out_word_t;

    // per-cell load controls
    typedef struct packed {
        logic load_prev;
        logic load_next;
    } cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/olist_in_if.sv
`default_nettype none

interface olist_in_if;
    logic                valid;
    logic                ready;
    olist_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/olist_out_if.sv
`default_nettype none

interface olist_out_if;
    logic                 valid;
    logic                 ready;
    olist_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/olist_cell.sv
`default_nettype none

module olist_cell (
    input  wire                       clk,
    input  wire olist_pkg::cell_cmd_t cmd,
    input  wire olist_pkg::entry_t    entry_prev,
    input  wire olist_pkg::entry_t    entry_next,
    input  wire olist_pkg::entry_t    key,
    output olist_pkg::entry_t         entry,
    output logic                      hit
);
    import olist_pkg::*;

    entry_t entry_reg;
    entry_t entry_next_val;

    always_comb
    begin
        entry_next_val = entry_reg;
        if (cmd.load_prev)
        begin
            entry_next_val = entry_prev;
        end
        else if (cmd.load_next)
        begin
            entry_next_val = entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next_val;
    end

    assign entry = entry_reg;
    assign hit   = (entry_reg == key);

endmodule

`default_nettype wire

### hw/rtl/ordered_list_push_find_delete.sv
`default_nettype none

// Ordered list of up to 16 words, newest at the front, held in a row of cells
// that compare against the key in parallel; a push shifts every cell away from
// the front, a delete shifts the cells from the match onwards towards it. One
// word is taken per cycle and its result lands in an output register on the next
// edge; a new word is taken while that result is waiting if the sink takes it in
// the same cycle. The per-cycle path is the row of equality compares followed by
// the first-match priority pick, which drives the shift enables of the cells. A
// push into a full list is dropped with status 2; find and delete report status
// 1 when nothing matches. Every result carries the count held after the operation.

module ordered_list_push_find_delete (
    input  wire         clk,
    input  wire         rst_n,
    olist_in_if.sink    req,
    olist_out_if.source rsp
);
    import olist_pkg::*;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    out_word_t           rsp_word_reg;
    out_word_t           rsp_word_next;
    logic [CNT_BITS-1:0] used_reg;
    logic [CNT_BITS-1:0] used_next;

    logic                  accept;
    entry_t                key;
    entry_t                cell_entry [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_hit;
    logic [LIST_DEPTH-1:0] live_hit;
    cell_cmd_t             cell_cmd [LIST_DEPTH];
    logic [IDX_BITS-1:0]   hit_idx;
    logic                  any_hit;
    logic                  full;
    logic                  do_push;
    logic                  do_del;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign key       = VALUE_BITS'(req.data.value);
    assign full      = (used_reg == CNT_BITS'(LIST_DEPTH));
    assign do_push   = accept && (req.data.mode == MODE_PUSH) && !full;
    assign do_del    = accept && (req.data.mode == MODE_DEL) && any_hit;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            entry_t prev_w;
            entry_t next_w;

            if (g == 0)
            begin : g_front
                assign prev_w = key;
            end
            else
            begin : g_mid
                assign prev_w = cell_entry[g-1];
            end

            if (g == LIST_DEPTH - 1)
            begin : g_back
                assign next_w = cell_entry[g];
            end
            else
            begin : g_inner
                assign next_w = cell_entry[g+1];
            end

            olist_cell u_cell (
                .clk        (clk),
                .cmd        (cell_cmd[g]),
                .entry_prev (prev_w),
                .entry_next (next_w),
                .key        (key),
                .entry      (cell_entry[g]),
                .hit        (cell_hit[g])
            );
        end
    endgenerate

    // first live match from the front
    always_comb
    begin
        hit_idx = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            live_hit[i] = cell_hit[i] && (CNT_BITS'(i) < used_reg);
            if (live_hit[i])
            begin
                hit_idx = IDX_BITS'(i);
            end
        end
        any_hit = |live_hit;
    end

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            cell_cmd[i].load_prev = do_push;
            cell_cmd[i].load_next = do_del && (IDX_BITS'(i) >= hit_idx);
        end
    end

    always_comb
    begin
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            rsp_valid_next         = 1'b1;
            rsp_word_next.found    = 1'b0;
            rsp_word_next.position = '0;
            rsp_word_next.status   = STAT_DONE;

            unique case (req.data.mode)
                MODE_PUSH:
                begin
                    if (full)
                    begin
                        rsp_word_next.status = STAT_FULL;
                    end
                    else
                    begin
                        used_next = used_reg + 1'b1;
                    end
                end
                MODE_FIND, MODE_DEL:
                begin
                    if (any_hit)
                    begin
                        rsp_word_next.found    = 1'b1;
                        rsp_word_next.position = POS_W'(hit_idx);
                        if (req.data.mode == MODE_DEL)
                        begin
                            used_next = used_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_word_next.status = STAT_MISS;
                    end
                end
                MODE_CLEAR:
                begin
                    used_next = '0;
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase

            rsp_word_next.count = COUNT_W'(used_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word_reg;

endmodule

`default_nettype wire

### tb/ordered_list_push_find_delete_tb.sv
`timescale 1ns / 1ps

module ordered_list_push_find_delete_tb;

    import olist_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;
    localparam int RAND_ITEMS  = 500;

    logic clk;
    logic rst_n;

    olist_in_if  req ();
    olist_out_if rsp ();

    ordered_list_push_find_delete dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // list model
    entry_t held [LIST_DEPTH];
    int     held_cnt;

    in_word_t  items_q [$];
    out_word_t due_results [$];

    int n_given;
    int n_taken;
    int mismatches;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic out_word_t list_apply(in_word_t w);
        out_word_t r;
        int        hit;
        int        i;
        r   = '0;
        hit = -1;
        case (w.mode)
            MODE_PUSH:
            begin
                if (held_cnt >= LIST_DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    for (i = held_cnt; i > 0; i--)
                        held[i] = held[i-1];
                    held[0] = w.value;
                    held_cnt++;
                end
            end
            MODE_FIND, MODE_DEL:
            begin
                for (i = 0; i < held_cnt; i++)
                    if (hit < 0 && held[i] == entry_t'(w.value))
                        hit = i;
                if (hit < 0)
                begin
                    r.status = STAT_MISS;
                end
                else
                begin
                    r.found    = 1'b1;
                    r.position = hit[POS_W-1:0];
                    if (w.mode == MODE_DEL)
                    begin
                        for (i = hit; i + 1 < held_cnt; i++)
                            held[i] = held[i+1];
                        held_cnt--;
                    end
                end
            end
            default:
            begin
                held_cnt = 0;
            end
        endcase
        r.count = held_cnt[COUNT_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                due_results.push_back(list_apply(req.data));
                n_taken++;
            end
            if (!req.valid || req.ready)
            begin
                if (items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req.valid <= 1'b1;
                    req.data  <= items_q.pop_front();
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: found=%0d pos=%0d count=%0d status=%0d",
                                 rsp.data.found, rsp.data.position, rsp.data.count,
                                 rsp.data.status);
                end
                else if (rsp.data.found    !== due_results[0].found    ||
                         rsp.data.position !== due_results[0].position ||
                         rsp.data.count    !== due_results[0].count    ||
                         rsp.data.status   !== due_results[0].status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp found=%0d pos=%0d count=%0d status=%0d, got found=%0d pos=%0d count=%0d status=%0d",
                                 due_results[0].found, due_results[0].position,
                                 due_results[0].count, due_results[0].status,
                                 rsp.data.found, rsp.data.position, rsp.data.count,
                                 rsp.data.status);
                    void'(due_results.pop_front());
                end
                else
                begin
                    void'(due_results.pop_front());
                end
            end
            rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic add_item(input logic [MODE_W-1:0] m, input entry_t v);
        in_word_t w;
        w.mode  = m;
        w.value = v;
        items_q.push_back(w);
        n_given++;
    endtask

    task automatic gen_random(input int n);
        entry_t            pool [6];
        int                push_w;
        int                del_w;
        int                k;
        int                j;
        int                r;
        logic [MODE_W-1:0] m;
        entry_t            v;
        push_w = 35;
        del_w  = 25;
        for (k = 0; k < n; k++)
        begin
            // new value pool and op mix every 40 words: fill, churn or drain
            if (k % 40 == 0)
            begin
                for (j = 0; j < 6; j++)
                    case ($urandom_range(0, 5))
                        0:       pool[j] = 32'h8000_0000;
                        1:       pool[j] = 32'h7FFF_FFFF;
                        2:       pool[j] = '1;
                        3:       pool[j] = '0;
                        default: pool[j] = $urandom();
                    endcase
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_w = 72;
                        del_w  = 8;
                    end
                    1:
                    begin
                        push_w = 35;
                        del_w  = 25;
                    end
                    default:
                    begin
                        push_w = 15;
                        del_w  = 50;
                    end
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                m = MODE_CLEAR;
            else if (r < 2 + push_w)
                m = MODE_PUSH;
            else if (r < 2 + push_w + del_w)
                m = MODE_DEL;
            else
                m = MODE_FIND;
            if ($urandom_range(0, 9) < 7)
                v = pool[$urandom_range(0, 5)];
            else
                v = $urandom();
            add_item(m, v);
        end
    endtask

    task automatic drain();
        while (n_taken != n_given || due_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        gen_random(RAND_ITEMS);
        drain();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.data       = '0;
        rsp.ready      = 1'b0;
        n_given        = 0;
        n_taken        = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        held_cnt       = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list, extremes, duplicates, front / middle / back hits, clear
        add_item(MODE_FIND,  32'd7);
        add_item(MODE_DEL,   32'd7);
        add_item(MODE_PUSH,  32'h8000_0000);
        add_item(MODE_PUSH,  32'h7FFF_FFFF);
        add_item(MODE_PUSH,  32'hFFFF_FFFF);
        add_item(MODE_PUSH,  32'h0000_0000);
        add_item(MODE_PUSH,  32'hFFFF_FFFF);
        add_item(MODE_FIND,  32'hFFFF_FFFF);
        add_item(MODE_FIND,  32'h8000_0000);
        add_item(MODE_DEL,   32'h7FFF_FFFF);
        add_item(MODE_DEL,   32'h1234_5678);
        add_item(MODE_FIND,  32'h0000_0000);
        add_item(MODE_DEL,   32'hFFFF_FFFF);
        add_item(MODE_DEL,   32'h8000_0000);
        add_item(MODE_CLEAR, 32'hA5A5_A5A5);
        add_item(MODE_FIND,  32'h0000_0000);
        add_item(MODE_PUSH,  32'h5A5A_5A5A);
        add_item(MODE_DEL,   32'h5A5A_5A5A);
        drain();

        run_phase(0, 0);
        run_phase(55, 0);
        run_phase(0, 55);
        run_phase(22, 22);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
